/* rtl/ipf_pkg.sv */
package ipf_pkg;

	localparam int COORD_W = 24;            // vertex and point coordinates
	localparam int DIFF_W = COORD_W + 1;    // vertex minus point
	localparam int PROD_W = 2 * DIFF_W;     // one square or cross product
	localparam int MIN_W = PROD_W + 1;      // lifted length or 2x2 minor
	localparam int LO_W = 25;               // low slice of a minor operand, unsigned
	localparam int HI_W = MIN_W - LO_W;     // high slice, signed
	localparam int PP_W = 2 * (HI_W + 1);   // one partial product
	localparam int DET_W = 2 * MIN_W;       // determinant, exact
	localparam int ID_BITS_DEF = 19;
	localparam int CFG_IDX_W = 3;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [MIN_W-1:0] minor_t;
	typedef logic signed [PP_W-1:0] pp_t;
	typedef logic signed [DET_W-1:0] det_t;

	// register map of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_A_X = 3'd0,
		REG_A_Y = 3'd1,
		REG_B_X = 3'd2,
		REG_B_Y = 3'd3,
		REG_C_X = 3'd4,
		REG_C_Y = 3'd5
	} reg_idx_t;

	// load enables of the two stages inside the wide multiplier
	typedef struct packed {
		logic s4;
		logic s5;
	} ipf_adv_t;

endpackage

/* rtl/ipf_term_mul.sv */
// Exact product of two 51-bit signed values, split into four 27x27 signed partial
// products (stage 4) and recombined (stage 5).
module ipf_term_mul (
	input  logic              clk,
	input  ipf_pkg::ipf_adv_t adv,
	input  ipf_pkg::minor_t   op_a,
	input  ipf_pkg::minor_t   op_b,
	output ipf_pkg::det_t     term
);
	import ipf_pkg::*;

	logic signed [HI_W:0] a_lo, b_lo, a_hs, b_hs;
	pp_t pp_ll_s4, pp_lh_s4, pp_hl_s4, pp_hh_s4;
	det_t term_s5;

	// low slices are unsigned: zero-extend into a signed operand
	assign a_lo = $signed({{(HI_W + 1 - LO_W){1'b0}}, op_a[LO_W-1:0]});
	assign b_lo = $signed({{(HI_W + 1 - LO_W){1'b0}}, op_b[LO_W-1:0]});
	// high slices carry the sign
	assign a_hs = $signed({op_a[MIN_W-1], op_a[MIN_W-1:LO_W]});
	assign b_hs = $signed({op_b[MIN_W-1], op_b[MIN_W-1:LO_W]});

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			pp_ll_s4 <= a_lo * b_lo;
			pp_lh_s4 <= a_lo * b_hs;
			pp_hl_s4 <= a_hs * b_lo;
			pp_hh_s4 <= a_hs * b_hs;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s5) begin
			term_s5 <= (DET_W'(pp_hh_s4) <<< (2 * LO_W))
				+ (DET_W'(pp_lh_s4) <<< LO_W)
				+ (DET_W'(pp_hl_s4) <<< LO_W)
				+ DET_W'(pp_ll_s4);
		end
	end

	assign term = term_s5;

endmodule

/* rtl/incircle_point_filter_top.sv */
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    point_x, point_y, point_tag, last_point
// out       output     out_valid / out_ready  result_tag, last_result
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Seven register stages, one point per cycle while the output is not stalled;
// the depth comes from splitting each 51x51 product over two stages. Each
// stage holds while the one after it is full and stalled, so bubbles are
// squeezed out and nothing is lost or repeated. Reset clears valid bits and
// the vertex registers; cfg_ready is always high.
module incircle_point_filter_top #(
	parameter int ID_BITS = ipf_pkg::ID_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  ipf_pkg::coord_t                 point_x,
	input  ipf_pkg::coord_t                 point_y,
	input  logic signed [ID_BITS:0]         point_tag,
	input  logic                            last_point,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [ID_BITS:0]         result_tag,
	output logic                            last_result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ipf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  ipf_pkg::coord_t                 cfg_data
);
	import ipf_pkg::*;

	localparam int NSTG = 7;

	coord_t ax_q, ay_q, bx_q, by_q, cx_q, cy_q;

	logic [NSTG:1] vld;
	logic [NSTG:1] adv;

	diff_t xa_s1, ya_s1, xb_s1, yb_s1, xc_s1, yc_s1;
	prod_t sq_xa_s2, sq_ya_s2, sq_xb_s2, sq_yb_s2, sq_xc_s2, sq_yc_s2;
	prod_t xbyc_s2, xcyb_s2, xayc_s2, xcya_s2, xayb_s2, xbya_s2;
	minor_t la_s3, lb_s3, lc_s3, m1_s3, m2_s3, m3_s3;
	det_t t1, t2, t3;
	det_t det_s6;
	logic in_circle;

	logic signed [ID_BITS:0] tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6, tag_s7;
	logic last_s1, last_s2, last_s3, last_s4, last_s5, last_s6, last_s7;

	ipf_adv_t mul_adv;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_q <= '0;
			ay_q <= '0;
			bx_q <= '0;
			by_q <= '0;
			cx_q <= '0;
			cy_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_A_X: ax_q <= cfg_data;
				REG_A_Y: ay_q <= cfg_data;
				REG_B_X: bx_q <= cfg_data;
				REG_B_Y: by_q <= cfg_data;
				REG_C_X: cx_q <= cfg_data;
				REG_C_Y: cy_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// a stage loads when empty or when the stage after it loads
	always_comb begin
		adv[NSTG] = !vld[NSTG] || out_ready;
		for (int k = NSTG - 1; k >= 1; k--) begin
			adv[k] = !vld[k] || adv[k+1];
		end
	end

	assign in_ready = adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (adv[1]) begin
				vld[1] <= in_valid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (adv[k]) begin
					vld[k] <= vld[k-1];
				end
			end
		end
	end

	// stage 1: translate the triangle so the point sits at the origin
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			xa_s1 <= DIFF_W'(ax_q) - DIFF_W'(point_x);
			ya_s1 <= DIFF_W'(ay_q) - DIFF_W'(point_y);
			xb_s1 <= DIFF_W'(bx_q) - DIFF_W'(point_x);
			yb_s1 <= DIFF_W'(by_q) - DIFF_W'(point_y);
			xc_s1 <= DIFF_W'(cx_q) - DIFF_W'(point_x);
			yc_s1 <= DIFF_W'(cy_q) - DIFF_W'(point_y);
			tag_s1 <= point_tag;
			last_s1 <= last_point;
		end
	end

	// stage 2: squares and cross products
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			sq_xa_s2 <= xa_s1 * xa_s1;
			sq_ya_s2 <= ya_s1 * ya_s1;
			sq_xb_s2 <= xb_s1 * xb_s1;
			sq_yb_s2 <= yb_s1 * yb_s1;
			sq_xc_s2 <= xc_s1 * xc_s1;
			sq_yc_s2 <= yc_s1 * yc_s1;
			xbyc_s2 <= xb_s1 * yc_s1;
			xcyb_s2 <= xc_s1 * yb_s1;
			xayc_s2 <= xa_s1 * yc_s1;
			xcya_s2 <= xc_s1 * ya_s1;
			xayb_s2 <= xa_s1 * yb_s1;
			xbya_s2 <= xb_s1 * ya_s1;
			tag_s2 <= tag_s1;
			last_s2 <= last_s1;
		end
	end

	// stage 3: lifted lengths and 2x2 minors
	always_ff @(posedge clk) begin
		if (adv[3]) begin
			la_s3 <= MIN_W'(sq_xa_s2) + MIN_W'(sq_ya_s2);
			lb_s3 <= MIN_W'(sq_xb_s2) + MIN_W'(sq_yb_s2);
			lc_s3 <= MIN_W'(sq_xc_s2) + MIN_W'(sq_yc_s2);
			m1_s3 <= MIN_W'(xbyc_s2) - MIN_W'(xcyb_s2);
			m2_s3 <= MIN_W'(xayc_s2) - MIN_W'(xcya_s2);
			m3_s3 <= MIN_W'(xayb_s2) - MIN_W'(xbya_s2);
			tag_s3 <= tag_s2;
			last_s3 <= last_s2;
		end
	end

	// stages 4 and 5: exact 51x51 products
	assign mul_adv.s4 = adv[4];
	assign mul_adv.s5 = adv[5];

	ipf_term_mul u_mul1 (.clk(clk), .adv(mul_adv), .op_a(la_s3), .op_b(m1_s3), .term(t1));
	ipf_term_mul u_mul2 (.clk(clk), .adv(mul_adv), .op_a(lb_s3), .op_b(m2_s3), .term(t2));
	ipf_term_mul u_mul3 (.clk(clk), .adv(mul_adv), .op_a(lc_s3), .op_b(m3_s3), .term(t3));

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			tag_s4 <= tag_s3;
			last_s4 <= last_s3;
		end
		if (adv[5]) begin
			tag_s5 <= tag_s4;
			last_s5 <= last_s4;
		end
	end

	// stage 6: cofactor expansion along the lifted column
	always_ff @(posedge clk) begin
		if (adv[6]) begin
			det_s6 <= t1 - t2 + t3;
			tag_s6 <= tag_s5;
			last_s6 <= last_s5;
		end
	end

	// stage 7: output register; on the circle counts as outside
	assign in_circle = !det_s6[DET_W-1] && (det_s6 != '0);

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			tag_s7 <= in_circle ? tag_s6 : '1;
			last_s7 <= last_s6;
		end
	end

	assign out_valid = vld[NSTG];
	assign result_tag = tag_s7;
	assign last_result = last_s7;

endmodule

/* test/tb_incircle_point_filter_top.sv */
`timescale 1ns / 100ps

module tb_incircle_point_filter_top;
	import ipf_pkg::*;

	localparam int TAG_W = ID_BITS_DEF + 1;
	localparam int PIPE_LAT = 7;
	localparam int LONG_HOLD = 120;
	localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED_HI = 3'd7;

	typedef logic signed [TAG_W-1:0] tag_t;
	localparam tag_t REJECT_TAG = -1;

	typedef struct {
		coord_t x;
		coord_t y;
		tag_t tag;
		logic last;
	} point_t;

	typedef struct {
		tag_t tag;
		logic last;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	coord_t point_x = '0;
	coord_t point_y = '0;
	tag_t point_tag = '0;
	logic last_point = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	tag_t result_tag;
	logic last_result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	coord_t cfg_data = '0;

	// stimulus waiting for the driver, verdicts waiting for the monitor
	point_t pending_points[$];
	verdict_t verdicts_due[$];
	coord_t tri_reg [6];

	int errors = 0;
	int points_sent = 0;
	int kept_cnt = 0;
	int rejected_cnt = 0;
	int reg_writes = 0;
	int bp_requests = 0;
	int bp_served = 0;

	incircle_point_filter_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.point_x(point_x),
		.point_y(point_y),
		.point_tag(point_tag),
		.last_point(last_point),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_tag(result_tag),
		.last_result(last_result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// exact sign of the lifted 3x3 determinant; 128 bits hold it with room to spare
	function automatic tag_t incircle_tag(coord_t px, coord_t py, tag_t tag);
		logic signed [127:0] xa, ya, xb, yb, xc, yc, la, lb, lc, det;
		xa = tri_reg[REG_A_X] - px;
		ya = tri_reg[REG_A_Y] - py;
		xb = tri_reg[REG_B_X] - px;
		yb = tri_reg[REG_B_Y] - py;
		xc = tri_reg[REG_C_X] - px;
		yc = tri_reg[REG_C_Y] - py;
		la = xa * xa + ya * ya;
		lb = xb * xb + yb * yb;
		lc = xc * xc + yc * yc;
		det = la * (xb * yc - xc * yb) - lb * (xa * yc - xc * ya) + lc * (xa * yb - xb * ya);
		return (det > 0) ? tag : REJECT_TAG;
	endfunction

	function automatic int pause_len();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return $urandom_range(3, 1);
		else if (r < 90)
			return $urandom_range(8, 4);
		return $urandom_range(40, 15);
	endfunction

	function automatic coord_t rand_span(int lo, int hi);
		return coord_t'(lo + int'($urandom_range(hi - lo)));
	endfunction

	function automatic tag_t rand_tag();
		int r;
		r = $urandom_range(99);
		if (r < 12)
			return REJECT_TAG;
		else if (r < 18)
			return tag_t'(-1 - int'($urandom_range(524287)));
		else if (r < 26)
			return tag_t'($urandom());
		return tag_t'($urandom_range(524287));
	endfunction

	task automatic add_point(coord_t x, coord_t y, tag_t tag, logic last);
		point_t p;
		p.x = x;
		p.y = y;
		p.tag = tag;
		p.last = last;
		pending_points.push_back(p);
	endtask

	task automatic report_mismatch(string what, int want, int got);
		$display("mismatch at %0t ns: %s expected %0d got %0d", $time, what, want, got);
		errors++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, coord_t val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx <= REG_C_Y)
			tri_reg[idx] = val;
		reg_writes++;
	endtask

	task automatic set_triangle(coord_t ax, coord_t ay, coord_t bx, coord_t by,
			coord_t cx, coord_t cy);
		write_reg(REG_A_X, ax);
		write_reg(REG_A_Y, ay);
		write_reg(REG_B_X, bx);
		write_reg(REG_B_Y, by);
		write_reg(REG_C_X, cx);
		write_reg(REG_C_Y, cy);
	endtask

	// block is empty once every point went in and every verdict came out
	task automatic wait_idle();
		do @(posedge clk);
		while (pending_points.size() != 0 || verdicts_due.size() != 0 || in_valid);
		repeat (PIPE_LAT + 3) @(posedge clk);
	endtask

	// driver
	int gap_left = 0;
	int drv_quiet = 0;
	always @(posedge clk or negedge arst_n) begin
		point_t nxt;
		verdict_t v;
		if (!arst_n) begin
			in_valid <= 1'b0;
			point_x <= '0;
			point_y <= '0;
			point_tag <= '0;
			last_point <= 1'b0;
			gap_left = 0;
		end else begin
			if (in_valid && in_ready) begin
				v.tag = incircle_tag(point_x, point_y, point_tag);
				v.last = last_point;
				verdicts_due.push_back(v);
				points_sent++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_points.size() != 0) begin
					nxt = pending_points.pop_front();
					point_x <= nxt.x;
					point_y <= nxt.y;
					point_tag <= nxt.tag;
					last_point <= nxt.last;
					in_valid <= 1'b1;
					if (drv_quiet > 0)
						drv_quiet--;
					else if ($urandom_range(99) < 3)
						drv_quiet = $urandom_range(60, 20);
					else if ($urandom_range(99) < 40)
						gap_left = pause_len();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	int hold_left = 0;
	int mon_quiet = 0;
	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		logic rdy;
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (verdicts_due.size() == 0) begin
					report_mismatch("result with nothing pending, tag", 0, int'(result_tag));
				end else begin
					want = verdicts_due.pop_front();
					if (result_tag !== want.tag)
						report_mismatch("result_tag", int'(want.tag), int'(result_tag));
					if (last_result !== want.last)
						report_mismatch("last_result", int'(want.last), int'(last_result));
				end
				if (result_tag == REJECT_TAG)
					rejected_cnt++;
				else
					kept_cnt++;
			end
			if (bp_served != bp_requests) begin
				bp_served++;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (mon_quiet > 0) begin
				mon_quiet--;
				rdy = 1'b1;
			end else begin
				rdy = 1'b1;
				if ($urandom_range(99) < 3)
					mon_quiet = $urandom_range(60, 20);
				else if ($urandom_range(99) < 30)
					hold_left = pause_len();
			end
			out_ready <= rdy;
		end
	end

	initial begin
		#12_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		foreach (tri_reg[i])
			tri_reg[i] = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// circle of radius 1000 around the origin, vertices counterclockwise
		set_triangle(1000, 0, 0, 1000, -1000, 0);
		@(negedge clk);
		add_point(0, 0, 5, 1'b0);
		add_point(0, -1000, 6, 1'b0);
		add_point(600, 800, 7, 1'b0);
		add_point(-600, -800, 8, 1'b0);
		add_point(2000, 0, 9, 1'b0);
		add_point(0, 0, REJECT_TAG, 1'b0);
		add_point(10, -10, -7, 1'b0);
		add_point(0, 999, 524287, 1'b0);
		add_point(1, 1, -524288, 1'b1);
		add_point(-8388608, -8388608, 11, 1'b0);
		add_point(8388607, 8388607, 12, 1'b1);
		add_point(8388607, -8388608, 13, 1'b0);
		add_point(999, 0, 14, 1'b0);
		add_point(1000, 1, 15, 1'b1);
		wait_idle();

		// all three vertices in one spot: determinant is always zero
		set_triangle(5, -5, 5, -5, 5, -5);
		@(negedge clk);
		add_point(0, 0, 20, 1'b0);
		add_point(5, -5, 21, 1'b0);
		add_point(-8388608, 8388607, 22, 1'b1);
		wait_idle();

		// collinear vertices on y = 2x/3
		set_triangle(-300, -200, 0, 0, 600, 400);
		@(negedge clk);
		add_point(300, 200, 23, 1'b0);
		add_point(-3000, -2000, 24, 1'b0);
		add_point(0, 50, 25, 1'b0);
		add_point(0, -50, 26, 1'b1);
		wait_idle();

		// moderate random triangle, then a long output stall while points keep coming
		set_triangle(rand_span(-4096, 4095), rand_span(-4096, 4095),
			rand_span(-4096, 4095), rand_span(-4096, 4095),
			rand_span(-4096, 4095), rand_span(-4096, 4095));
		@(negedge clk);
		for (int i = 0; i < 200; i++)
			add_point(rand_span(-6000, 6000), rand_span(-6000, 6000), rand_tag(),
				$urandom_range(7) == 0);
		bp_requests = bp_requests + 1;
		wait_idle();

		// tiny grid: points on the circle show up often here
		set_triangle(rand_span(-6, 6), rand_span(-6, 6), rand_span(-6, 6),
			rand_span(-6, 6), rand_span(-6, 6), rand_span(-6, 6));
		@(negedge clk);
		for (int i = 0; i < 100; i++)
			add_point(rand_span(-8, 8), rand_span(-8, 8), rand_tag(), $urandom_range(7) == 0);
		wait_idle();
		set_triangle(3, 4, -4, 3, -3, -4);
		@(negedge clk);
		for (int i = 0; i < 100; i++)
			add_point(rand_span(-8, 8), rand_span(-8, 8), rand_tag(), $urandom_range(7) == 0);
		wait_idle();

		// widest counterclockwise triangle, full-range points
		set_triangle(-8388608, -8388608, 8388607, -8388608, -8388608, 8388607);
		@(negedge clk);
		add_point(8388607, 8388607, 30, 1'b0);
		add_point(-8388608, -8388608, 31, 1'b0);
		for (int i = 0; i < 150; i++)
			add_point(coord_t'($urandom()), coord_t'($urandom()), rand_tag(),
				$urandom_range(7) == 0);
		bp_requests = bp_requests + 1;
		wait_idle();

		// full-range random triangle; unmapped indexes must leave the vertices alone
		set_triangle(coord_t'($urandom()), coord_t'($urandom()), coord_t'($urandom()),
			coord_t'($urandom()), coord_t'($urandom()), coord_t'($urandom()));
		write_reg(IDX_UNMAPPED_LO, 8388607);
		write_reg(IDX_UNMAPPED_HI, -8388608);
		@(negedge clk);
		for (int i = 0; i < 150; i++)
			add_point(coord_t'($urandom()), coord_t'($urandom()), rand_tag(),
				$urandom_range(7) == 0);
		wait_idle();

		// degenerate again, now with points on the line mixed with random points
		set_triangle(-1200, 900, 400, -300, 2000, -1500);
		@(negedge clk);
		for (int i = 0; i < 60; i++) begin
			if (i % 2 == 0)
				add_point(coord_t'(-4 * (i - 30)), coord_t'(3 * (i - 30)), rand_tag(), 1'b0);
			else
				add_point(rand_span(-3000, 3000), rand_span(-3000, 3000), rand_tag(),
					$urandom_range(7) == 0);
		end
		wait_idle();

		// fresh random configuration per batch
		for (int b = 0; b < 4; b++) begin
			set_triangle(rand_span(-65536, 65535), rand_span(-65536, 65535),
				rand_span(-65536, 65535), rand_span(-65536, 65535),
				rand_span(-65536, 65535), rand_span(-65536, 65535));
			@(negedge clk);
			for (int i = 0; i < 30; i++)
				add_point(rand_span(-100000, 100000), rand_span(-100000, 100000), rand_tag(),
					i == 29);
			wait_idle();
		end

		if (verdicts_due.size() != 0)
			report_mismatch("results still pending", 0, verdicts_due.size());
		$display("filtered %0d points: %0d kept inside the circle, %0d rejected",
			points_sent, kept_cnt, rejected_cnt);
		$display("%0d register writes, %0d long output stalls", reg_writes, bp_served);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* sim.f */
rtl/ipf_pkg.sv
rtl/ipf_term_mul.sv
rtl/incircle_point_filter_top.sv
test/tb_incircle_point_filter_top.sv
